[rtl/rsac_pkg.sv]
// ----------------------------------------------------------------------------
// RFID scan access controller package
// Word types, register indexes, result codes and timing constants.
// ----------------------------------------------------------------------------
package rsac_pkg;

  // Bytes carried by a UID field
  localparam int unsigned UidBytes = 10;

  // Scans longer than this are rejected
  localparam logic [3:0] MAX_UID_BYTES = 4'd10;

  // Result display hold time
  localparam logic [31:0] DISPLAY_HOLD_MS = 32'd3000;

  // Feedback pulse shapes
  localparam logic [7:0] GRANT_ON_MS  = 8'd200;
  localparam logic [6:0] GRANT_OFF_MS = 7'd0;
  localparam logic [1:0] GRANT_PULSES = 2'd1;
  localparam logic [7:0] DENY_ON_MS   = 8'd100;
  localparam logic [6:0] DENY_OFF_MS  = 7'd100;
  localparam logic [1:0] DENY_PULSES  = 2'd3;

  // Register reset values
  localparam logic [63:0] TAG_ONE_UID_RST = 64'h0000_0000_063E_F5C3;
  localparam logic [63:0] TAG_TWO_UID_RST = 64'h0000_0000_06F0_2A2C;
  localparam logic [3:0]  TAG_LEN_RST     = 4'd4;
  localparam logic [15:0] DUP_WINDOW_RST  = 16'd3000;

  // Register indexes
  localparam logic [2:0] REG_TAG_ONE_LOW  = 3'd0;
  localparam logic [2:0] REG_TAG_ONE_HIGH = 3'd1;
  localparam logic [2:0] REG_TAG_ONE_LEN  = 3'd2;
  localparam logic [2:0] REG_TAG_TWO_LOW  = 3'd3;
  localparam logic [2:0] REG_TAG_TWO_HIGH = 3'd4;
  localparam logic [2:0] REG_TAG_TWO_LEN  = 3'd5;
  localparam logic [2:0] REG_DUP_WINDOW   = 3'd6;

  // Scan outcome codes
  localparam logic [2:0] OUTC_NONE    = 3'd0;
  localparam logic [2:0] OUTC_GRANTED = 3'd1;
  localparam logic [2:0] OUTC_DENIED  = 3'd2;
  localparam logic [2:0] OUTC_DUP     = 3'd3;
  localparam logic [2:0] OUTC_LONG    = 3'd4;

  // Matched tag codes
  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_ONE  = 2'd1;
  localparam logic [1:0] TAG_TWO  = 2'd2;

  // Function codes
  localparam logic FUNC_TIME = 1'b0;
  localparam logic FUNC_SCAN = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
    logic [3:0]  uid_length;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  scan_outcome;
    logic [1:0]  matched_tag;
    logic [31:0] scan_id;
    logic        feedback_on;
    logic        result_showing;
  } out_word_t;

endpackage

[rtl/rfid_scan_access_controller.sv]
// ----------------------------------------------------------------------------
// RFID scan access controller
// Duplicate filtering, tag matching, event numbering, feedback pulse
// sequencing and result display hold for card scan words.
//
//   channel   signals                              direction
//   in        in_valid_i  in_ready_o  in_word_i    word in
//   out       out_valid_o out_ready_i out_word_o   word out
//   cfg       cfg_valid_i cfg_ready_o cfg_index_i  register write in
//             cfg_data_i
//
// One word per cycle sustained while the output is not stalled; a word passes
// through the input register, then the result register after one pass of logic.
// All state updates in the single cycle a word moves into the result register.
// Reset restores the tag, window and state defaults at once; no sweep.
// A stalled result holds; the input register still takes one more word.
// Configuration writes are always taken (cfg_ready_o is tied high).
// ----------------------------------------------------------------------------
module rfid_scan_access_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rsac_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rsac_pkg::out_word_t out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import rsac_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ON   = 2'd1,
    PH_OFF  = 2'd2
  } phase_e;

  // Compare the first len bytes of two UIDs of equal length
  function automatic logic uid_eq(logic [63:0] alo, logic [15:0] ahi, logic [3:0] alen,
                                  logic [63:0] blo, logic [15:0] bhi, logic [3:0] blen);
    logic [8*UidBytes-1:0] diff;
    logic                  ok;
    diff = {ahi, alo} ^ {bhi, blo};
    ok   = (alen == blen) && (alen <= 4'(UidBytes));
    for (int unsigned i = 0; i < UidBytes; i++) begin
      if ((4'(i) < alen) && (diff[i*8 +: 8] != 8'h00)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Configuration registers
  logic [63:0] tag_one_low_q, tag_two_low_q;
  logic [15:0] tag_one_high_q, tag_two_high_q;
  logic [3:0]  tag_one_len_q, tag_two_len_q;
  logic [15:0] dup_window_q;

  // Pipeline registers
  logic      in_vld_q, out_vld_q;
  in_word_t  in_q;
  out_word_t out_q, out_d;

  // Scan and feedback state
  logic [63:0] last_low_q, last_low_d;
  logic [15:0] last_high_q, last_high_d;
  logic [3:0]  last_len_q, last_len_d;
  logic [31:0] last_time_q, last_time_d;
  logic        have_last_q, have_last_d;
  logic [31:0] next_id_q, next_id_d;
  phase_e      phase_q, phase_d;
  logic [31:0] phase_start_q, phase_start_d;
  logic [7:0]  on_time_q, on_time_d;
  logic [6:0]  off_time_q, off_time_d;
  logic [1:0]  target_q, target_d;
  logic [1:0]  done_q, done_d;
  logic        hold_q, hold_d;
  logic [31:0] hold_start_q, hold_start_d;

  logic        advance;
  logic [31:0] fb_elapsed;
  logic [1:0]  done_inc;
  logic        is_dup;
  logic        match_one, match_two;

  // Move the held word into the result register when it is free
  assign advance     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign fb_elapsed = in_q.now_ms - phase_start_q;
  assign done_inc   = done_q + 2'd1;
  assign match_one  = uid_eq(in_q.uid_low, in_q.uid_high, in_q.uid_length,
                             tag_one_low_q, tag_one_high_q, tag_one_len_q);
  assign match_two  = uid_eq(in_q.uid_low, in_q.uid_high, in_q.uid_length,
                             tag_two_low_q, tag_two_high_q, tag_two_len_q);
  assign is_dup     = have_last_q
                      && uid_eq(in_q.uid_low, in_q.uid_high, in_q.uid_length,
                                last_low_q, last_high_q, last_len_q)
                      && ((in_q.now_ms - last_time_q) < {16'd0, dup_window_q});

  // Step the sequencer, the display hold, then the scan
  always_comb begin
    last_low_d    = last_low_q;
    last_high_d   = last_high_q;
    last_len_d    = last_len_q;
    last_time_d   = last_time_q;
    have_last_d   = have_last_q;
    next_id_d     = next_id_q;
    phase_d       = phase_q;
    phase_start_d = phase_start_q;
    on_time_d     = on_time_q;
    off_time_d    = off_time_q;
    target_d      = target_q;
    done_d        = done_q;
    hold_d        = hold_q;
    hold_start_d  = hold_start_q;
    out_d         = '0;

    // Advance the feedback pulse by at most one transition
    case (phase_q)
      PH_ON: begin
        if (fb_elapsed >= {24'd0, on_time_q}) begin
          if (done_inc >= target_q) begin
            phase_d  = PH_IDLE;
            target_d = 2'd0;
            done_d   = 2'd0;
          end else begin
            phase_d       = PH_OFF;
            phase_start_d = in_q.now_ms;
            done_d        = done_inc;
          end
        end
      end
      PH_OFF: begin
        if (fb_elapsed >= {25'd0, off_time_q}) begin
          phase_d       = PH_ON;
          phase_start_d = in_q.now_ms;
        end
      end
      default: begin
      end
    endcase

    // Drop the display hold once it has run out
    if (hold_q && ((in_q.now_ms - hold_start_q) >= DISPLAY_HOLD_MS)) begin
      hold_d = 1'b0;
    end

    // Handle the scan
    if (in_q.func == FUNC_SCAN) begin
      if (is_dup) begin
        out_d.scan_outcome = OUTC_DUP;
      end else if (in_q.uid_length > MAX_UID_BYTES) begin
        out_d.scan_outcome = OUTC_LONG;
      end else begin
        out_d.scan_id = next_id_q;
        next_id_d     = next_id_q + 32'd1;
        if (match_one) begin
          out_d.matched_tag = TAG_ONE;
        end else if (match_two) begin
          out_d.matched_tag = TAG_TWO;
        end
        last_low_d   = in_q.uid_low;
        last_high_d  = in_q.uid_high;
        last_len_d   = in_q.uid_length;
        last_time_d  = in_q.now_ms;
        have_last_d  = 1'b1;
        hold_d       = 1'b1;
        hold_start_d = in_q.now_ms;
        if (match_one || match_two) begin
          out_d.scan_outcome = OUTC_GRANTED;
          on_time_d          = GRANT_ON_MS;
          off_time_d         = GRANT_OFF_MS;
          target_d           = GRANT_PULSES;
        end else begin
          out_d.scan_outcome = OUTC_DENIED;
          on_time_d          = DENY_ON_MS;
          off_time_d         = DENY_OFF_MS;
          target_d           = DENY_PULSES;
        end
        done_d        = 2'd0;
        phase_start_d = in_q.now_ms;
        phase_d       = PH_ON;
      end
    end

    out_d.feedback_on    = (phase_d == PH_ON);
    out_d.result_showing = hold_d;
  end

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_one_low_q  <= TAG_ONE_UID_RST;
      tag_one_high_q <= 16'd0;
      tag_one_len_q  <= TAG_LEN_RST;
      tag_two_low_q  <= TAG_TWO_UID_RST;
      tag_two_high_q <= 16'd0;
      tag_two_len_q  <= TAG_LEN_RST;
      dup_window_q   <= DUP_WINDOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TAG_ONE_LOW:  tag_one_low_q  <= cfg_data_i;
        REG_TAG_ONE_HIGH: tag_one_high_q <= cfg_data_i[15:0];
        REG_TAG_ONE_LEN:  tag_one_len_q  <= cfg_data_i[3:0];
        REG_TAG_TWO_LOW:  tag_two_low_q  <= cfg_data_i;
        REG_TAG_TWO_HIGH: tag_two_high_q <= cfg_data_i[15:0];
        REG_TAG_TWO_LEN:  tag_two_len_q  <= cfg_data_i[3:0];
        REG_DUP_WINDOW:   dup_window_q   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Handshake control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Capture payload words
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Hold scan and feedback state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_low_q    <= 64'd0;
      last_high_q   <= 16'd0;
      last_len_q    <= 4'd0;
      last_time_q   <= 32'd0;
      have_last_q   <= 1'b0;
      next_id_q     <= 32'd1;
      phase_q       <= PH_IDLE;
      phase_start_q <= 32'd0;
      on_time_q     <= 8'd0;
      off_time_q    <= 7'd0;
      target_q      <= 2'd0;
      done_q        <= 2'd0;
      hold_q        <= 1'b0;
      hold_start_q  <= 32'd0;
    end else if (advance) begin
      last_low_q    <= last_low_d;
      last_high_q   <= last_high_d;
      last_len_q    <= last_len_d;
      last_time_q   <= last_time_d;
      have_last_q   <= have_last_d;
      next_id_q     <= next_id_d;
      phase_q       <= phase_d;
      phase_start_q <= phase_start_d;
      on_time_q     <= on_time_d;
      off_time_q    <= off_time_d;
      target_q      <= target_d;
      done_q        <= done_d;
      hold_q        <= hold_d;
      hold_start_q  <= hold_start_d;
    end
  end

  // An idle sequencer carries no pending pulses
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (target_q == 2'd0 && done_q == 2'd0))
    else $error("idle sequencer with pending pulse count");

  // Only granted or denied scans carry an event id or a tag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.scan_outcome != OUTC_GRANTED && out_q.scan_outcome != OUTC_DENIED)
    |-> (out_q.scan_id == 32'd0 && out_q.matched_tag == TAG_NONE))
    else $error("event id or tag on a scan that made no event");

  // An accepted scan turns on feedback and the display hold
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.scan_outcome == OUTC_GRANTED || out_q.scan_outcome == OUTC_DENIED))
    |-> (out_q.feedback_on && out_q.result_showing))
    else $error("accepted scan without feedback or display hold");

  // The event counter moves by one exactly when an event is made
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (next_id_q == $past(next_id_q)
                 + ((out_q.scan_outcome == OUTC_GRANTED
                     || out_q.scan_outcome == OUTC_DENIED) ? 32'd1 : 32'd0)))
    else $error("event counter out of step with results");

  // Input side stalls only while both registers are full and output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

endmodule
